### rtl/drr_pkg.sv
package drr_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 9;
    localparam int WORD_W  = 32;
    localparam int MONTHS  = 12;
    localparam int MIDX_W  = 4;
    localparam int Q100_W  = 8;

    localparam logic [YEAR_W-1:0] YEAR_RESET = 14'd2000;

    // Reciprocal of 100 scaled by 2^19; exact floor for every 14-bit year.
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [1:0] FUNC_CHECK    = 2'd0;
    localparam logic [1:0] FUNC_RESERVE  = 2'd1;
    localparam logic [1:0] FUNC_CANCEL   = 2'd2;
    localparam logic [1:0] FUNC_VALIDATE = 2'd3;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] LEN_31 = 5'd31;
    localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
    localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
    localparam logic [DAY_W-1:0] LEN_28 = 5'd28;

    typedef struct packed {
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } range_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = LEN_31;
        if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
        begin
            len = LEN_30;
        end
        else if (m == MONTH_FEB)
        begin
            len = leap ? LEN_29 : LEN_28;
        end
        return len;
    endfunction

endpackage

### rtl/drr_date_check.sv
module drr_date_check (
    input  drr_pkg::range_t rng,
    input  logic            leap,
    output logic            valid
);

    logic months_ok;
    logic days_ok;
    logic order_ok;
    logic len_ok;

    always_comb
    begin
        months_ok = (rng.start_month >= drr_pkg::MONTH_JAN)
                 && (rng.start_month <= drr_pkg::MONTH_DEC)
                 && (rng.end_month >= drr_pkg::MONTH_JAN)
                 && (rng.end_month <= drr_pkg::MONTH_DEC)
                 && (rng.end_month >= rng.start_month);
        days_ok   = (rng.start_day != '0) && (rng.end_day != '0);
        order_ok  = !((rng.start_month == rng.end_month) && (rng.start_day >= rng.end_day));
        len_ok    = (rng.start_day <= drr_pkg::month_len(rng.start_month, leap))
                 && (rng.end_day <= drr_pkg::month_len(rng.end_month, leap));
        valid     = months_ok && days_ok && order_ok && len_ok;
    end

endmodule

### rtl/day_range_reservation_map.sv
// Day range reservation map: one booked bit for every day of the configured year.
// Input channel (in_valid/in_ready) carries one request beat: func, start date
// (inclusive) and end date (exclusive). Output channel (out_valid/out_ready)
// returns one result beat per request: ok, day_count and rejected.
// Write the year register through cfg_we/cfg_wdata only while the block is idle;
// the block itself does not enforce this. A request passes through the states
// DIV, LEAP and CHECK; a rejected or validate-only request then goes to DONE,
// any other request first walks the N months the range spans (1 to 12) in WALK.
// The map is kept as twelve 32-bit month words and one shared mask unit visits
// one month word per cycle. DONE loads the output register once it is free.
// The block takes one request at a time; in_ready is high only while the
// sequencer is idle, but a new request is taken while the last result still
// waits in the output register. If the receiver stalls, the result stays in
// the output register and the next request finishes its work and then waits
// until that register is free.
// Reset clears every booked bit (all days free), sets the year to 2000 and
// empties the output register.
module day_range_reservation_map (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [drr_pkg::YEAR_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [drr_pkg::MONTH_W-1:0]  start_month,
    input  logic [drr_pkg::DAY_W-1:0]    start_day,
    input  logic [drr_pkg::MONTH_W-1:0]  end_month,
    input  logic [drr_pkg::DAY_W-1:0]    end_day,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         ok,
    output logic [drr_pkg::COUNT_W-1:0]  day_count,
    output logic                         rejected
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_LEAP  = 6'b000100,
        S_CHECK = 6'b001000,
        S_WALK  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [drr_pkg::YEAR_W-1:0]  year_reg;
    logic [drr_pkg::Q100_W-1:0]  q100_reg, q100_next;
    logic                        leap_reg, leap_next;
    logic [1:0]                  func_reg;
    drr_pkg::range_t             rng_reg;
    logic [drr_pkg::MIDX_W-1:0]  midx_reg, midx_next;
    logic                        res_ok_reg, res_ok_next;
    logic                        res_rej_reg, res_rej_next;
    logic [drr_pkg::COUNT_W-1:0] res_count_reg, res_count_next;
    logic                        out_valid_reg;
    logic                        ok_reg;
    logic                        rejected_reg;
    logic [drr_pkg::COUNT_W-1:0] day_count_reg;
    logic [drr_pkg::WORD_W-1:0]  booked_reg [drr_pkg::MONTHS];

    logic                        range_ok;
    logic [26:0]                 year_prod;
    logic [14:0]                 q100_times;
    logic [drr_pkg::MONTH_W-1:0] cur_month;
    logic [drr_pkg::DAY_W-1:0]   lo;
    logic [drr_pkg::DAY_W-1:0]   hi;
    logic [drr_pkg::WORD_W-1:0]  mask;
    logic [drr_pkg::WORD_W-1:0]  cur_word;
    logic [drr_pkg::WORD_W-1:0]  new_word;
    logic                        last_month;
    logic                        accept;
    logic                        out_free;

    drr_date_check u_date_check (
        .rng   (rng_reg),
        .leap  (leap_reg),
        .valid (range_ok)
    );

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign day_count = day_count_reg;
    assign rejected  = rejected_reg;

    always_comb
    begin
        year_prod  = {13'd0, year_reg} * {14'd0, drr_pkg::RECIP_100};
        q100_times = ({7'd0, q100_reg} << 6) + ({7'd0, q100_reg} << 5)
                   + ({7'd0, q100_reg} << 2);

        cur_month  = midx_reg + 4'd1;
        last_month = (cur_month == rng_reg.end_month);
        lo         = (cur_month == rng_reg.start_month) ? rng_reg.start_day - 5'd1 : '0;
        hi         = last_month ? rng_reg.end_day - 5'd1
                                : drr_pkg::month_len(cur_month, leap_reg);
        mask       = ({drr_pkg::WORD_W{1'b1}} << lo) & ~({drr_pkg::WORD_W{1'b1}} << hi);
        cur_word   = booked_reg[midx_reg];
        new_word   = (func_reg == drr_pkg::FUNC_RESERVE) ? (cur_word | mask)
                                                          : (cur_word & ~mask);
    end

    always_comb
    begin
        state_next     = state_reg;
        q100_next      = q100_reg;
        leap_next      = leap_reg;
        midx_next      = midx_reg;
        res_ok_next    = res_ok_reg;
        res_rej_next   = res_rej_reg;
        res_count_next = res_count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                q100_next  = year_prod[drr_pkg::RECIP_SHIFT +: drr_pkg::Q100_W];
                state_next = S_LEAP;
            end
            S_LEAP:
            begin
                leap_next  = (year_reg[1:0] == 2'b00)
                          && (({1'b0, year_reg} != q100_times) || (q100_reg[1:0] == 2'b00));
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                res_count_next = '0;
                midx_next      = rng_reg.start_month - 4'd1;
                if (!range_ok || func_reg == drr_pkg::FUNC_VALIDATE)
                begin
                    res_ok_next  = range_ok;
                    res_rej_next = !range_ok;
                    state_next   = S_DONE;
                end
                else
                begin
                    res_ok_next  = 1'b1;
                    res_rej_next = 1'b0;
                    state_next   = S_WALK;
                end
            end
            S_WALK:
            begin
                if (func_reg == drr_pkg::FUNC_CHECK && (cur_word & mask) != '0)
                begin
                    res_ok_next = 1'b0;
                end
                if (func_reg == drr_pkg::FUNC_RESERVE && hi > lo)
                begin
                    res_count_next = res_count_reg + {4'd0, hi - lo};
                end
                if (last_month)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    midx_next = midx_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            year_reg      <= drr_pkg::YEAR_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < drr_pkg::MONTHS; i++)
            begin
                booked_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                year_reg <= cfg_wdata;
            end
            if (state_reg == S_WALK
                && (func_reg == drr_pkg::FUNC_RESERVE || func_reg == drr_pkg::FUNC_CANCEL))
            begin
                booked_reg[midx_reg] <= new_word;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q100_reg      <= q100_next;
        leap_reg      <= leap_next;
        midx_reg      <= midx_next;
        res_ok_reg    <= res_ok_next;
        res_rej_reg   <= res_rej_next;
        res_count_reg <= res_count_next;
        if (accept)
        begin
            func_reg            <= func;
            rng_reg.start_month <= start_month;
            rng_reg.start_day   <= start_day;
            rng_reg.end_month   <= end_month;
            rng_reg.end_day     <= end_day;
        end
        if (state_reg == S_DONE && out_free)
        begin
            ok_reg        <= res_ok_reg;
            rejected_reg  <= res_rej_reg;
            day_count_reg <= res_count_reg;
        end
    end

endmodule
